// ===== src/nul_byte_profiler_core_defines.svh =====
// Assertion helpers for the byte profiler
`ifndef NUL_BYTE_PROFILER_CORE_DEFINES_SVH
`define NUL_BYTE_PROFILER_CORE_DEFINES_SVH

// Same-cycle check on clk, masked while in reset
`define NBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication on clk, masked while in reset
`define NBP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== src/nbp_pkg.sv =====
package nbp_pkg;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_LE   = 2'd1,
    KIND_BE   = 2'd2
  } kind_t;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_CNT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PAIRS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BINARY_RATIO = 2'd1;

  localparam logic [15:0] MIN_PAIRS_RST    = 16'd4;
  localparam logic [15:0] BINARY_RATIO_RST = 16'd6554;

  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [15:0] PAIR_MAX = 16'hFFFF;

endpackage

// ===== src/nul_byte_profiler_core.sv =====
// Channel  Handshake            Payload
// in       in_valid / in_stall  in_byte_value[7:0], in_is_last
// out      out_valid / out_stall out counts[31:0] x3, out_zero_heavy, out_interleave_kind
// cfg      cfg_valid / cfg_ready cfg_index[1:0], cfg_data[15:0]
//
// One byte per cycle while in_stall is low; counters update in the accept cycle.
// After its last byte a result passes the capture, ratio multiply and compare registers in order.
// Three result stages hold a result each; in_stall rises only when all are full.
// Synchronous active-low reset: min_pairs 4, binary_ratio 6554, counters cleared.
// cfg_ready is always high.
`include "nul_byte_profiler_core_defines.svh"

module nul_byte_profiler_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_byte_value,
  input  logic                              in_is_last,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nbp_pkg::OUT_CNT_W-1:0]     out_byte_count,
  output logic [nbp_pkg::OUT_CNT_W-1:0]     out_zero_count,
  output logic [nbp_pkg::OUT_CNT_W-1:0]     out_leading_zeros,
  output logic                              out_zero_heavy,
  output nbp_pkg::kind_t                    out_interleave_kind,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nbp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import nbp_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int PW = COUNT_WIDTH + 16;
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  // config
  logic [15:0] min_pairs_r;
  logic [15:0] binary_ratio_r;

  // per-buffer state
  logic [CW-1:0] byte_total_r, byte_total_nxt;
  logic [CW-1:0] zero_total_r, zero_total_nxt;
  logic [CW-1:0] lead_run_r, lead_run_nxt;
  logic          still_leading_r, still_leading_nxt;
  logic          pair_first_zero_r, pair_first_zero_nxt;
  logic          le_ok_r, le_ok_nxt;
  logic          be_ok_r, be_ok_nxt;
  logic          mid_pair_r, mid_pair_nxt;
  logic [15:0]   pair_cnt_r, pair_cnt_nxt;

  // result stages
  logic          a_vld_r, b_vld_r, out_valid_r;
  logic          a_ready, b_ready, o_ready;
  logic [CW-1:0] a_total_r, a_zero_r, a_lead_r;
  logic [CW-1:0] b_total_r, b_zero_r, b_lead_r;
  kind_t         a_kind_r, b_kind_r, kind_nxt;
  logic [PW-1:0] b_prod_r;

  logic [OUT_CNT_W-1:0] out_total_r, out_zero_r, out_lead_r;
  logic                 out_bin_r;
  kind_t                out_kind_r;

  logic in_fire, is_zero, enough;

  function automatic logic [OUT_CNT_W-1:0] clamp_out(input logic [CW-1:0] v);
    logic [63:0] ext;
    ext = 64'(v);
    return (|ext[63:OUT_CNT_W]) ? '1 : ext[OUT_CNT_W-1:0];
  endfunction

  assign o_ready  = !out_valid_r || !out_stall;
  assign b_ready  = !b_vld_r || o_ready;
  assign a_ready  = !a_vld_r || b_ready;
  assign in_stall = !a_ready;
  assign in_fire  = in_valid && !in_stall;
  assign is_zero  = (in_byte_value == ZERO_BYTE);
  assign cfg_ready = 1'b1;

  always_comb begin
    byte_total_nxt = (byte_total_r == '1) ? byte_total_r : byte_total_r + CNT_ONE;
    zero_total_nxt = zero_total_r;
    if (is_zero && zero_total_r != '1) begin
      zero_total_nxt = zero_total_r + CNT_ONE;
    end
    lead_run_nxt = lead_run_r;
    if (still_leading_r && is_zero && lead_run_r != '1) begin
      lead_run_nxt = lead_run_r + CNT_ONE;
    end
    still_leading_nxt   = still_leading_r && is_zero;
    pair_first_zero_nxt = pair_first_zero_r;
    le_ok_nxt           = le_ok_r;
    be_ok_nxt           = be_ok_r;
    pair_cnt_nxt        = pair_cnt_r;
    mid_pair_nxt        = !mid_pair_r;
    if (!mid_pair_r) begin
      pair_first_zero_nxt = is_zero;
    end else begin
      le_ok_nxt = le_ok_r && !pair_first_zero_r && is_zero;
      be_ok_nxt = be_ok_r && pair_first_zero_r && !is_zero;
      pair_cnt_nxt = (pair_cnt_r == PAIR_MAX) ? pair_cnt_r : pair_cnt_r + 16'd1;
    end
    enough = (pair_cnt_nxt >= min_pairs_r);
    if (enough && le_ok_nxt) begin
      kind_nxt = KIND_LE;
    end else if (enough && be_ok_nxt) begin
      kind_nxt = KIND_BE;
    end else begin
      kind_nxt = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pairs_r    <= MIN_PAIRS_RST;
      binary_ratio_r <= BINARY_RATIO_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_PAIRS:    min_pairs_r    <= cfg_data;
        REG_BINARY_RATIO: binary_ratio_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_is_last)) begin
      byte_total_r      <= '0;
      zero_total_r      <= '0;
      lead_run_r        <= '0;
      still_leading_r   <= 1'b1;
      pair_first_zero_r <= 1'b0;
      le_ok_r           <= 1'b1;
      be_ok_r           <= 1'b1;
      mid_pair_r        <= 1'b0;
      pair_cnt_r        <= '0;
    end else if (in_fire) begin
      byte_total_r      <= byte_total_nxt;
      zero_total_r      <= zero_total_nxt;
      lead_run_r        <= lead_run_nxt;
      still_leading_r   <= still_leading_nxt;
      pair_first_zero_r <= pair_first_zero_nxt;
      le_ok_r           <= le_ok_nxt;
      be_ok_r           <= be_ok_nxt;
      mid_pair_r        <= mid_pair_nxt;
      pair_cnt_r        <= pair_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_vld_r <= in_fire && in_is_last;
      end
      if (b_ready) begin
        b_vld_r <= a_vld_r;
      end
      if (o_ready) begin
        out_valid_r <= b_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_is_last) begin
      a_total_r <= byte_total_nxt;
      a_zero_r  <= zero_total_nxt;
      a_lead_r  <= lead_run_nxt;
      a_kind_r  <= kind_nxt;
    end
    if (b_ready && a_vld_r) begin
      b_total_r <= a_total_r;
      b_zero_r  <= a_zero_r;
      b_lead_r  <= a_lead_r;
      b_kind_r  <= a_kind_r;
      b_prod_r  <= PW'(a_total_r) * PW'(binary_ratio_r);
    end
    if (o_ready && b_vld_r) begin
      out_total_r <= clamp_out(b_total_r);
      out_zero_r  <= clamp_out(b_zero_r);
      out_lead_r  <= clamp_out(b_lead_r);
      out_bin_r   <= ({b_zero_r, 16'h0000} > b_prod_r);
      out_kind_r  <= b_kind_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_byte_count      = out_total_r;
  assign out_zero_count      = out_zero_r;
  assign out_leading_zeros   = out_lead_r;
  assign out_zero_heavy      = out_bin_r;
  assign out_interleave_kind = out_kind_r;

  `NBP_ASSERT(a_bin_needs_zeros, !out_valid_r || !out_bin_r || (out_zero_r != '0), "zero-heavy flag with no zeros")
  `NBP_ASSERT(a_lead_le_zero, !out_valid_r || (out_lead_r <= out_zero_r), "leading run exceeds zero count")
  `NBP_ASSERT(a_zero_le_total, !out_valid_r || (out_zero_r <= out_total_r), "zero count exceeds byte count")
  `NBP_ASSERT_NEXT(a_last_clears, in_fire && in_is_last, (byte_total_r == '0) && a_vld_r, "last beat did not close buffer")

endmodule

// ===== tb/sv/nul_byte_profiler_core_tb.sv =====
module nul_byte_profiler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nbp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {SHAPE_RANDOM, SHAPE_LE, SHAPE_BE, SHAPE_ZEROS, SHAPE_LEADING} shape_t;

  typedef struct {
    logic [OUT_CNT_W-1:0] total;
    logic [OUT_CNT_W-1:0] zeros;
    logic [OUT_CNT_W-1:0] lead;
    logic                 binary;
    kind_t                kind;
  } profile_t;

  class profile_scoreboard;
    logic [15:0] min_pairs;
    logic [15:0] ratio;
    logic [31:0] byte_cnt;
    logic [31:0] zero_cnt;
    logic [31:0] lead_cnt;
    logic [15:0] pair_cnt;
    bit leading;
    bit first_zero;
    bit le_ok;
    bit be_ok;
    bit mid_pair;
    profile_t pending_q[$];
    int errors;

    function new();
      min_pairs = MIN_PAIRS_RST;
      ratio = BINARY_RATIO_RST;
      errors = 0;
      clear_buffer();
    endfunction

    function void clear_buffer();
      byte_cnt = '0;
      zero_cnt = '0;
      lead_cnt = '0;
      pair_cnt = '0;
      leading = 1'b1;
      first_zero = 1'b0;
      le_ok = 1'b1;
      be_ok = 1'b1;
      mid_pair = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MIN_PAIRS: min_pairs = data;
        REG_BINARY_RATIO: ratio = data;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      bit z;
      bit enough;
      logic [63:0] scaled_zeros;
      logic [63:0] scaled_total;
      profile_t p;
      z = (b == ZERO_BYTE);
      if (byte_cnt != '1) byte_cnt++;
      if (z && zero_cnt != '1) zero_cnt++;
      if (leading) begin
        if (z) begin
          if (lead_cnt != '1) lead_cnt++;
        end else begin
          leading = 1'b0;
        end
      end
      if (!mid_pair) begin
        first_zero = z;
        mid_pair = 1'b1;
      end else begin
        if (first_zero || !z) le_ok = 1'b0;
        if (!first_zero || z) be_ok = 1'b0;
        if (pair_cnt != PAIR_MAX) pair_cnt++;
        mid_pair = 1'b0;
      end
      if (last) begin
        enough = (pair_cnt >= min_pairs);
        scaled_zeros = {16'd0, zero_cnt, 16'd0};
        scaled_total = 64'(byte_cnt) * 64'(ratio);
        p.total = byte_cnt;
        p.zeros = zero_cnt;
        p.lead = lead_cnt;
        p.binary = (scaled_zeros > scaled_total);
        if (enough && le_ok) p.kind = KIND_LE;
        else if (enough && be_ok) p.kind = KIND_BE;
        else p.kind = KIND_NONE;
        pending_q.push_back(p);
        clear_buffer();
      end
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(profile_t got);
      profile_t want;
      if (pending_q.size() == 0) begin
        report("result beat with no buffer outstanding");
        return;
      end
      want = pending_q.pop_front();
      if (got.total !== want.total)
        report($sformatf("byte count got %0d want %0d", got.total, want.total));
      if (got.zeros !== want.zeros)
        report($sformatf("zero_count got %0d want %0d", got.zeros, want.zeros));
      if (got.lead !== want.lead)
        report($sformatf("leading_zeros got %0d want %0d", got.lead, want.lead));
      if (got.binary !== want.binary)
        report($sformatf("zero-heavy flag got %b want %b", got.binary, want.binary));
      if (got.kind !== want.kind)
        report($sformatf("interleave_kind got %0d want %0d", got.kind, want.kind));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_byte_value;
  logic in_is_last;
  logic out_valid;
  logic out_stall;
  logic [OUT_CNT_W-1:0] out_byte_count;
  logic [OUT_CNT_W-1:0] out_zero_count;
  logic [OUT_CNT_W-1:0] out_leading_zeros;
  logic out_zero_heavy;
  kind_t out_interleave_kind;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit calm = 1'b0;
  bit hold_request = 1'b0;
  logic [7:0] buf_q[$];
  profile_scoreboard sb = new();

  nul_byte_profiler_core dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] nonzero_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic void fill_buffer(int len);
    shape_t shape;
    int r;
    int lead;
    r = $urandom_range(0, 9);
    shape = (r < 3) ? SHAPE_LE : (r < 6) ? SHAPE_BE : (r == 6) ? SHAPE_RANDOM :
            (r == 7) ? SHAPE_ZEROS : SHAPE_LEADING;
    lead = $urandom_range(0, len);
    buf_q.delete();
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_LE: buf_q.push_back((i % 2) ? ZERO_BYTE : nonzero_byte());
        SHAPE_BE: buf_q.push_back((i % 2) ? nonzero_byte() : ZERO_BYTE);
        SHAPE_ZEROS: buf_q.push_back(($urandom_range(0, 7) != 0) ? ZERO_BYTE : 8'($urandom));
        SHAPE_LEADING: buf_q.push_back((i < lead) ? ZERO_BYTE : 8'($urandom));
        default: buf_q.push_back(($urandom_range(0, 3) == 0) ? ZERO_BYTE : 8'($urandom));
      endcase
    end
    // occasionally break a pattern
    if ($urandom_range(0, 7) == 0) buf_q[$urandom_range(0, len - 1)] = 8'($urandom);
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= b;
    in_is_last <= last;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, last);
  endtask

  task automatic send_queue();
    foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1);
  endtask

  task automatic run_phase(int target);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      fill_buffer(len);
      send_queue();
      sent += len;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic [15:0] min_pairs, logic [15:0] ratio);
    write_reg(REG_MIN_PAIRS, min_pairs);
    write_reg(REG_BINARY_RATIO, ratio);
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int stall_left;
    profile_t got;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.total = out_byte_count;
        got.zeros = out_zero_count;
        got.lead = out_leading_zeros;
        got.binary = out_zero_heavy;
        got.kind = out_interleave_kind;
        sb.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_byte_value <= '0;
    in_is_last <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    buf_q = {ZERO_BYTE};
    send_queue();
    buf_q = {8'hFF};
    send_queue();
    buf_q = {8'h41, 8'h00, 8'h42, 8'h00, 8'h43, 8'h00, 8'h80, 8'h00, 8'h7F};
    send_queue();
    buf_q = {8'h00, 8'h41, 8'h00, 8'h42, 8'h00, 8'h43, 8'h00, 8'hFF};
    send_queue();
    buf_q = {8'h00, 8'h00, 8'h01, 8'h00};
    send_queue();
    run_phase(120);
    drain();

    configure(16'd0, 16'd0);
    run_phase(150);
    drain();

    configure(16'hFFFF, 16'hFFFF);
    run_phase(100);
    drain();

    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'($urandom));
    configure(16'd1, 16'h8000);
    // long sink hold-off while short buffers keep coming
    hold_request = 1'b1;
    repeat (40) begin
      fill_buffer($urandom_range(1, 2));
      send_queue();
    end
    run_phase(80);
    drain();

    calm = 1'b1;
    configure(16'($urandom_range(0, 10)), 16'($urandom));
    run_phase(120);
    drain();
    calm = 1'b0;

    repeat (3) begin
      configure(16'($urandom_range(0, 10)), 16'($urandom));
      run_phase(120);
      drain();
    end

    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
